// File: rtl/als_pkg.sv
// Package for the array list engine: item types, command and status codes,
// default sizes. No dependencies.
package als_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int INIT_LENGTH_DEF = 10;

  typedef enum logic [3:0] {
    CMD_GET        = 4'd0,
    CMD_SET        = 4'd1,
    CMD_PUSH_BACK  = 4'd2,
    CMD_PUSH_FRONT = 4'd3,
    CMD_INSERT     = 4'd4,
    CMD_POP_BACK   = 4'd5,
    CMD_POP_FRONT  = 4'd6,
    CMD_EXTRACT    = 4'd7,
    CMD_REVERSE    = 4'd8,
    CMD_ROTATE     = 4'd9,
    CMD_SUM        = 4'd10,
    CMD_COUNT_ODD  = 4'd11,
    CMD_SUM_EVEN   = 4'd12,
    CMD_SECOND_MAX = 4'd13
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [6:0]         index;
    logic [6:0]         end_position;
    logic signed [31:0] value;
    logic signed [31:0] shift_amount;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [6:0]         length;
  } out_t;

endpackage

// File: rtl/als_mem.sv
// Element store of the array list engine: one write port, two registered
// read ports. No dependencies.
module als_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/als_mod.sv
// Bit-serial remainder unit for the rotate amount: 32-bit dividend by the
// list length, one bit per cycle. No dependencies.
module als_mod #(
  parameter int LW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [LW-1:0] remainder
);

  logic          busy;
  logic [5:0]    steps;
  logic [31:0]   xs;
  logic [LW:0]   trial;

  assign trial = {remainder, xs[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= 6'd32;
        xs <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          remainder <= LW'(trial - {1'b0, divisor});
        end else begin
          remainder <= LW'(trial);
        end
        xs <= {xs[30:0], 1'b0};
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  done_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("remainder done without a running division");

  start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && remainder == '0)
    else $error("division start did not arm the unit");

  steps_bounded: assert property (@(posedge clk) disable iff (rst)
    steps <= 6'd32)
    else $error("division step count out of range");

endmodule

// File: rtl/array_list_engine.sv
// Array list engine: a variable-length list of signed 32-bit words kept in one
// synchronous memory. After reset the block clears the store and takes no item
// meanwhile; the list then holds INIT_LENGTH zeros, capped at DEPTH.
// Get and pop_back read the element through S_RDWAIT; set and push_back write
// it in S_DECODE. Insert, push_front, extract and pop_front shift the later
// elements one per cycle through the memory's read and write ports. Reverse
// swaps one pair at a time, writing one end in S_RV_WA and the other in
// S_RV_WB. Rotate runs a bit-serial remainder, then three reversals. Sum, odd
// count and even sum read one element per cycle; second maximum reads the list
// twice. Depends on als_pkg, als_mem, als_mod.
module array_list_engine #(
  parameter int DEPTH       = als_pkg::DEPTH_DEF,
  parameter int INIT_LENGTH = als_pkg::INIT_LENGTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  als_pkg::in_t  cmd_item,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output als_pkg::out_t rsp_item
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW   = $clog2(DEPTH + 1);
  localparam int WW   = ((LW > 7) ? LW : 7) + 1;
  localparam int INIT = (INIT_LENGTH > DEPTH) ? DEPTH : INIT_LENGTH;

  typedef enum logic [14:0] {
    S_CLEAR    = 15'b000000000000001,
    S_IDLE     = 15'b000000000000010,
    S_DECODE   = 15'b000000000000100,
    S_RDWAIT   = 15'b000000000001000,
    S_EXT_CAP  = 15'b000000000010000,
    S_MOVE     = 15'b000000000100000,
    S_INS_WR   = 15'b000000001000000,
    S_RV_RD    = 15'b000000010000000,
    S_RV_WA    = 15'b000000100000000,
    S_RV_WB    = 15'b000001000000000,
    S_REV_NEXT = 15'b000010000000000,
    S_ROT_MOD  = 15'b000100000000000,
    S_WALK     = 15'b001000000000000,
    S_FIN      = 15'b010000000000000,
    S_SPARE    = 15'b100000000000000
  } state_t;

  state_t             state;
  logic [LW-1:0]      len;
  als_pkg::in_t       it;
  als_pkg::cmd_e      cmd;
  logic [AW-1:0]      ptr;
  logic [LW-1:0]      cnt;
  logic               dir_up;
  logic               rd_q;
  logic [AW-1:0]      dst_q;
  logic [AW-1:0]      pos_q;
  logic [AW-1:0]      a;
  logic [AW-1:0]      b;
  logic [AW-1:0]      s;
  logic [1:0]         rph;
  logic               pass;
  logic [31:0]        tmp;
  logic [31:0]        acc;
  logic signed [31:0] mx;
  logic signed [31:0] mn;
  logic signed [31:0] best;
  logic [31:0]        res;
  als_pkg::status_e   sts;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      ra;
  logic [AW-1:0]      rb;
  logic [31:0]        rda;
  logic [31:0]        rdb;
  logic signed [31:0] e;

  logic               mod_start;
  logic               mod_done;
  logic [LW-1:0]      mod_r;
  logic [31:0]        mod_x;
  logic [LW-1:0]      rot_s;

  logic [WW-1:0]      n_w;
  logic [WW-1:0]      ix_w;
  logic [WW-1:0]      ep_w;
  logic [WW-1:0]      d_pos;
  logic               full;
  logic               empty;
  als_pkg::status_e   d_sts;

  assign cmd = als_pkg::cmd_e'(it.cmd);
  assign e = rda;
  assign cmd_stall = (state != S_IDLE);

  assign n_w   = WW'(len);
  assign ix_w  = WW'(it.index);
  assign ep_w  = WW'(it.end_position);
  assign full  = (n_w == WW'(DEPTH));
  assign empty = (n_w == '0);
  assign d_pos = (cmd == als_pkg::CMD_PUSH_FRONT || cmd == als_pkg::CMD_POP_FRONT) ?
                 '0 : ix_w - WW'(1);

  always_comb begin
    d_sts = als_pkg::ST_OK;
    case (cmd)
      als_pkg::CMD_GET, als_pkg::CMD_SET: begin
        if (ix_w >= n_w) d_sts = als_pkg::ST_BADIDX;
      end
      als_pkg::CMD_PUSH_BACK, als_pkg::CMD_PUSH_FRONT: begin
        if (full) d_sts = als_pkg::ST_FULL;
      end
      als_pkg::CMD_INSERT: begin
        if (full) d_sts = als_pkg::ST_FULL;
        else if (ix_w == '0 || ix_w > n_w + WW'(1)) d_sts = als_pkg::ST_BADIDX;
      end
      als_pkg::CMD_POP_BACK, als_pkg::CMD_POP_FRONT, als_pkg::CMD_ROTATE,
      als_pkg::CMD_SECOND_MAX: begin
        if (empty) d_sts = als_pkg::ST_EMPTY;
      end
      als_pkg::CMD_EXTRACT: begin
        if (empty) d_sts = als_pkg::ST_EMPTY;
        else if (ix_w == '0 || ix_w > n_w) d_sts = als_pkg::ST_BADIDX;
      end
      als_pkg::CMD_REVERSE: begin
        if (ix_w == '0 || ix_w > ep_w || ep_w > n_w) d_sts = als_pkg::ST_BADIDX;
      end
      default: d_sts = als_pkg::ST_OK;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = a;
    wdata = '0;
    ra = ptr;
    rb = b;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = ptr;
      end
      S_DECODE: begin
        if (d_sts == als_pkg::ST_OK) begin
          case (cmd)
            als_pkg::CMD_GET: ra = AW'(ix_w);
            als_pkg::CMD_SET: begin
              we = 1'b1;
              waddr = AW'(ix_w);
              wdata = it.value;
            end
            als_pkg::CMD_PUSH_BACK: begin
              we = 1'b1;
              waddr = AW'(n_w);
              wdata = it.value;
            end
            als_pkg::CMD_POP_BACK: ra = AW'(n_w - WW'(1));
            als_pkg::CMD_POP_FRONT, als_pkg::CMD_EXTRACT: ra = AW'(d_pos);
            default: ra = ptr;
          endcase
        end
      end
      S_MOVE: begin
        we = rd_q;
        waddr = dst_q;
        wdata = rda;
      end
      S_INS_WR: begin
        we = 1'b1;
        waddr = pos_q;
        wdata = it.value;
      end
      S_RV_RD: ra = a;
      S_RV_WA: begin
        we = 1'b1;
        waddr = a;
        wdata = rdb;
      end
      S_RV_WB: begin
        we = 1'b1;
        waddr = b;
        wdata = tmp;
        ra = a + AW'(1);
        rb = b - AW'(1);
      end
      S_IDLE, S_RDWAIT, S_EXT_CAP, S_REV_NEXT, S_ROT_MOD, S_WALK, S_FIN,
      S_SPARE: ra = ptr;
    endcase
  end

  assign mod_start = (state == S_DECODE) && (cmd == als_pkg::CMD_ROTATE) &&
                     (d_sts == als_pkg::ST_OK);
  assign mod_x = it.shift_amount[31] ? (32'd0 - it.shift_amount) : it.shift_amount;
  assign rot_s = (it.shift_amount[31] && mod_r != '0) ? (len - mod_r) : mod_r;

  als_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(ra),
    .raddr_b(rb),
    .rdata_a(rda),
    .rdata_b(rdb)
  );

  als_mod #(
    .LW(LW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_x),
    .divisor  (len),
    .done     (mod_done),
    .remainder(mod_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      len <= LW'(INIT);
      ptr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + AW'(1);
          if (ptr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            it <= cmd_item;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res <= (d_sts != als_pkg::ST_OK && cmd == als_pkg::CMD_GET) ? '1 : '0;
          sts <= d_sts;
          if (d_sts != als_pkg::ST_OK) begin
            state <= S_FIN;
          end else begin
            case (cmd)
              als_pkg::CMD_GET: state <= S_RDWAIT;
              als_pkg::CMD_POP_BACK: begin
                len <= len - LW'(1);
                state <= S_RDWAIT;
              end
              als_pkg::CMD_SET: state <= S_FIN;
              als_pkg::CMD_PUSH_BACK: begin
                len <= len + LW'(1);
                state <= S_FIN;
              end
              als_pkg::CMD_PUSH_FRONT, als_pkg::CMD_INSERT: begin
                len <= len + LW'(1);
                ptr <= AW'(n_w - WW'(1));
                cnt <= LW'(n_w - d_pos);
                dir_up <= 1'b0;
                rd_q <= 1'b0;
                pos_q <= AW'(d_pos);
                state <= S_MOVE;
              end
              als_pkg::CMD_POP_FRONT, als_pkg::CMD_EXTRACT: begin
                len <= len - LW'(1);
                pos_q <= AW'(d_pos);
                state <= S_EXT_CAP;
              end
              als_pkg::CMD_REVERSE: begin
                a <= AW'(ix_w - WW'(1));
                b <= AW'(ep_w - WW'(1));
                rph <= 2'd3;
                state <= S_RV_RD;
              end
              als_pkg::CMD_ROTATE: state <= S_ROT_MOD;
              als_pkg::CMD_SUM, als_pkg::CMD_COUNT_ODD, als_pkg::CMD_SUM_EVEN,
              als_pkg::CMD_SECOND_MAX: begin
                ptr <= '0;
                cnt <= len;
                rd_q <= 1'b0;
                acc <= '0;
                mx <= 32'sh80000000;
                mn <= 32'sh7fffffff;
                pass <= 1'b0;
                state <= S_WALK;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RDWAIT: begin
          res <= rda;
          state <= S_FIN;
        end
        S_EXT_CAP: begin
          res <= rda;
          ptr <= pos_q + AW'(1);
          cnt <= len - LW'(pos_q);
          dir_up <= 1'b1;
          rd_q <= 1'b0;
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (cnt != '0) begin
            ptr <= dir_up ? ptr + AW'(1) : ptr - AW'(1);
            dst_q <= dir_up ? ptr - AW'(1) : ptr + AW'(1);
            cnt <= cnt - LW'(1);
            rd_q <= 1'b1;
          end else begin
            rd_q <= 1'b0;
            state <= dir_up ? S_FIN : S_INS_WR;
          end
        end
        S_INS_WR: state <= S_FIN;
        S_RV_RD: state <= S_RV_WA;
        S_RV_WA: begin
          tmp <= rda;
          state <= S_RV_WB;
        end
        S_RV_WB: begin
          a <= a + AW'(1);
          b <= b - AW'(1);
          if (({1'b0, a} + (AW + 1)'(2)) < {1'b0, b}) state <= S_RV_WA;
          else state <= S_REV_NEXT;
        end
        S_REV_NEXT: begin
          case (rph)
            2'd0: begin
              a <= '0;
              b <= AW'(len - LW'(1));
              rph <= 2'd1;
              state <= S_RV_RD;
            end
            2'd1: begin
              a <= '0;
              b <= s - AW'(1);
              rph <= 2'd2;
              state <= S_RV_RD;
            end
            2'd2: begin
              a <= s;
              b <= AW'(len - LW'(1));
              rph <= 2'd3;
              state <= S_RV_RD;
            end
            default: state <= S_FIN;
          endcase
        end
        S_ROT_MOD: begin
          if (mod_done) begin
            s <= AW'(rot_s);
            rph <= 2'd0;
            state <= (rot_s == '0) ? S_FIN : S_REV_NEXT;
          end
        end
        S_WALK: begin
          if (cnt != '0) begin
            ptr <= ptr + AW'(1);
            cnt <= cnt - LW'(1);
            rd_q <= 1'b1;
          end else begin
            rd_q <= 1'b0;
          end
          if (rd_q) begin
            case (cmd)
              als_pkg::CMD_SUM: acc <= acc + rda;
              als_pkg::CMD_COUNT_ODD: acc <= acc + 32'(rda[0]);
              als_pkg::CMD_SUM_EVEN: if (!rda[0]) acc <= acc + rda;
              default: begin
                if (!pass) begin
                  if (e > mx) mx <= e;
                  if (e < mn) mn <= e;
                end else if (e != mx && e >= best) begin
                  best <= e;
                end
              end
            endcase
          end
          if (cnt == '0 && !rd_q) begin
            if (cmd == als_pkg::CMD_SECOND_MAX && !pass) begin
              pass <= 1'b1;
              ptr <= '0;
              cnt <= len;
              best <= mn;
            end else begin
              res <= (cmd == als_pkg::CMD_SECOND_MAX) ? best : acc;
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp_item.result_value <= res;
            rsp_item.status <= sts;
            rsp_item.length <= 7'(len);
            state <= S_IDLE;
          end
        end
        S_SPARE: state <= S_IDLE;
      endcase
    end
  end

  len_bounded: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(DEPTH))
    else $error("list length exceeds the store");

  accept_decodes: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> state == S_DECODE)
    else $error("accepted item not decoded");

  fin_delivers: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && (!rsp_valid || !rsp_stall) |=> rsp_valid && state == S_IDLE)
    else $error("finished command did not present its result");

  mod_in_rotate: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_ROT_MOD)
    else $error("remainder finished outside a rotate");

endmodule
